/* src/pht_pkg.sv */
// Package: shared types and constants of the page hotness tracker.
package pht_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_HOT    = 2'd2,
    MODE_TARGET = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EVT_RD,
    ST_EVT_WR,
    ST_FOLD_RD,
    ST_FOLD_WR,
    ST_DIE_HALF,
    ST_DIE_INC,
    ST_SUM,
    ST_SCAN,
    ST_HOT_RD,
    ST_HOT_CMP,
    ST_DONE
  } state_e;

  localparam int unsigned CfgIdxW       = 1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_KICK   = 1'd1;

  localparam int unsigned WinW   = 13;
  localparam int unsigned KickW  = 14;
  localparam int unsigned CountW = 13;
  localparam int unsigned TotalW = 14;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

endpackage

/* src/page_hotness_tracker.sv */
// Top level: page hotness tracker with a shared sequencer over page and die tables.
//
//  channel | direction | handshake                 | payload
//  in      | request   | in_valid_i / in_ready_o   | mode, lpage, package_req, die, want_rd_hot
//  out     | result    | out_valid_o / out_ready_i | wr_hot, rd_hot, target_found, target_*
//  cfg     | request   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A hotness query reads its page, compares and hands off the registered result; a
// write or read event also updates its page (skipped when the page lies beyond PAGES)
// and its die count first; a target query first sums the die write counts, then scans
// them through one multiplier. A window end adds a walk in which every page is read
// then written, then the die counts are halved.
// After reset a clearing pass zeroes the page memories; no request is taken
// meanwhile. A result waits in an output register; the next request is taken only
// once it has been delivered.
module page_hotness_tracker
  import pht_pkg::*;
#(
  parameter int unsigned PAGES            = 4096,
  parameter int unsigned PACKAGES         = 4,
  parameter int unsigned DIES_PER_PACKAGE = 4,
  parameter int unsigned FRACTION_BITS    = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic [11:0]             lpage_i,
  input  logic [1:0]              package_req_i,
  input  logic [1:0]              die_i,
  input  logic                    want_rd_hot_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    wr_hot_o,
  output logic                    rd_hot_o,
  output logic                    target_found_o,
  output logic [1:0]              target_package_o,
  output logic [1:0]              target_die_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  localparam int unsigned PageW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned PcntW = PageW + 1;
  localparam int unsigned DIES  = PACKAGES * DIES_PER_PACKAGE;
  localparam int unsigned DieW  = (DIES > 1) ? $clog2(DIES) : 1;
  localparam int unsigned DcntW = DieW + 1;
  localparam int unsigned AvgW  = CountW + FRACTION_BITS;
  localparam int unsigned SumW  = AvgW + PageW;
  localparam int unsigned DsumW = TotalW + DieW;
  localparam int unsigned ProdW = 2 * TotalW;

  state_e state_q, state_d;

  logic [WinW-1:0]  win_len_q;
  logic [KickW-1:0] kick_q;

  // Page memories: count and average per kind.
  logic [CountW-1:0] wcnt_mem [PAGES];
  logic [CountW-1:0] rcnt_mem [PAGES];
  logic [AvgW-1:0]   wavg_mem [PAGES];
  logic [AvgW-1:0]   ravg_mem [PAGES];
  logic [CountW-1:0] wcnt_rd_q, rcnt_rd_q;
  logic [AvgW-1:0]   wavg_rd_q, ravg_rd_q;

  logic [TotalW-1:0] dwr_q [DIES];
  logic [TotalW-1:0] drd_q [DIES];

  logic [SumW-1:0]   wsum_q, rsum_q, acc_q, acc_d;
  logic [TotalW-1:0] wseen_q, rseen_q;
  logic [WinW-1:0]   wpos_q, rpos_q;

  // Latched request.
  logic [1:0]  mode_q;
  logic [11:0] page_q;
  logic        die_ok_q, want_q, fold_q;
  logic [DieW-1:0] die_idx_q;

  logic [PcntW-1:0] idx_q, idx_d;
  logic [DcntW-1:0] didx_q, didx_d;

  logic [DsumW-1:0] dsum_q, dsum_d;
  logic [ProdW-1:0] best_q, best_d;
  logic             found_q, found_d;
  // Package and die of the scanned entry, and of the best one so far.
  logic [DieW-1:0]  spkg_q, spkg_d, sdie_q, sdie_d;
  logic [1:0]       best_pkg_q, best_pkg_d, best_die_q, best_die_d;
  logic             wh_q, rh_q;

  logic out_valid_q;
  logic is_read;
  assign is_read = (mode_q == MODE_READ);

  logic page_ok;
  assign page_ok = ({{(32-12){1'b0}}, page_q} < PAGES);

  logic [PageW-1:0] addr;
  logic             mem_we;
  logic [CountW-1:0] cnt_wdata;
  logic [AvgW-1:0]   avg_wdata;
  logic              avg_we;

  // Shared fold arithmetic on the selected kind.
  logic [CountW-1:0] cur_cnt;
  logic [AvgW-1:0]   cur_avg;
  logic [AvgW:0]     fold_sum;
  logic [AvgW-1:0]   new_avg;
  assign cur_cnt  = is_read ? rcnt_rd_q : wcnt_rd_q;
  assign cur_avg  = is_read ? ravg_rd_q : wavg_rd_q;
  assign fold_sum = {1'b0, cur_avg} + ({{(AvgW+1-CountW){1'b0}}, cur_cnt} << FRACTION_BITS);
  assign new_avg  = fold_sum[AvgW:1];

  logic [WinW-1:0] pos_next;
  logic            win_end;
  assign pos_next = (is_read ? rpos_q : wpos_q) + 1'b1;
  assign win_end  = (pos_next == win_len_q);

  // Die scan unit: one multiply per cycle.
  logic [DieW-1:0]  scan_i;
  logic [TotalW-1:0] dw, dr;
  logic [ProdW-1:0] prod;
  logic             elig, take;
  assign scan_i = didx_q[DieW-1:0];
  assign dw     = dwr_q[scan_i];
  assign dr     = drd_q[scan_i];
  assign prod   = dw * dr;
  assign elig   = ({{DieW{1'b0}}, dw} * DsumW'(DIES)) > dsum_q;
  assign take   = elig && (want_q ? (!found_q || prod < best_q) : (prod > best_q));

  // Hot compare: average * PAGES >= sum; a shift when PAGES is a power of two.
  logic [AvgW-1:0] hot_avg_w, hot_avg_r;
  logic            warm;
  assign hot_avg_w = page_ok ? wavg_rd_q : '0;
  assign hot_avg_r = page_ok ? ravg_rd_q : '0;
  assign warm      = (wseen_q >= kick_q) || (rseen_q >= kick_q);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    didx_d     = didx_q;
    acc_d      = acc_q;
    dsum_d     = dsum_q;
    best_d     = best_q;
    found_d    = found_q;
    spkg_d     = spkg_q;
    sdie_d     = sdie_q;
    best_pkg_d = best_pkg_q;
    best_die_d = best_die_q;
    addr       = PageW'(page_q);
    mem_we     = 1'b0;
    avg_we     = 1'b0;
    cnt_wdata  = '0;
    avg_wdata  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        addr   = idx_q[PageW-1:0];
        mem_we = 1'b1;
        avg_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == PcntW'(PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        idx_d   = '0;
        didx_d  = '0;
        acc_d   = '0;
        dsum_d  = '0;
        best_d  = '0;
        found_d = 1'b0;
        spkg_d  = '0;
        sdie_d  = '0;
        best_pkg_d = '0;
        best_die_d = '0;
        if (in_valid_i && in_ready_o) begin
          unique case (mode_e'(mode_i))
            MODE_WRITE, MODE_READ: state_d = ST_EVT_RD;
            MODE_TARGET:           state_d = ST_SUM;
            default:               state_d = ST_HOT_RD;
          endcase
        end
      end
      ST_EVT_RD: begin
        state_d = page_ok ? ST_EVT_WR : (win_end ? ST_FOLD_RD : ST_DIE_INC);
      end
      ST_EVT_WR: begin
        mem_we    = (cur_cnt != CountMax);
        cnt_wdata = cur_cnt + 1'b1;
        state_d   = fold_q ? ST_FOLD_RD : ST_DIE_INC;
      end
      ST_FOLD_RD: begin
        addr    = idx_q[PageW-1:0];
        state_d = ST_FOLD_WR;
      end
      ST_FOLD_WR: begin
        addr      = idx_q[PageW-1:0];
        mem_we    = 1'b1;
        avg_we    = 1'b1;
        avg_wdata = new_avg;
        acc_d     = acc_q + SumW'(new_avg);
        idx_d     = idx_q + 1'b1;
        state_d   = (idx_q == PcntW'(PAGES - 1)) ? ST_DIE_HALF : ST_FOLD_RD;
      end
      ST_DIE_HALF: state_d = ST_DIE_INC;
      ST_DIE_INC:  state_d = ST_HOT_RD;
      ST_SUM: begin
        dsum_d = dsum_q + DsumW'(dwr_q[scan_i]);
        didx_d = didx_q + 1'b1;
        if (didx_q == DcntW'(DIES - 1)) begin
          didx_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_d     = prod;
          found_d    = 1'b1;
          best_pkg_d = 2'(spkg_q);
          best_die_d = 2'(sdie_q);
        end
        // Advance die within package, then package.
        if (sdie_q == DieW'(DIES_PER_PACKAGE - 1)) begin
          sdie_d = '0;
          spkg_d = spkg_q + 1'b1;
        end else begin
          sdie_d = sdie_q + 1'b1;
        end
        didx_d = didx_q + 1'b1;
        if (didx_q == DcntW'(DIES - 1)) begin
          state_d = ST_HOT_RD;
        end
      end
      ST_HOT_RD:  state_d = ST_HOT_CMP;
      ST_HOT_CMP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      didx_q  <= '0;
      acc_q   <= '0;
      dsum_q  <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
      spkg_q  <= '0;
      sdie_q  <= '0;
      best_pkg_q <= '0;
      best_die_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      didx_q  <= didx_d;
      acc_q   <= acc_d;
      dsum_q  <= dsum_d;
      best_q  <= best_d;
      found_q <= found_d;
      spkg_q  <= spkg_d;
      sdie_q  <= sdie_d;
      best_pkg_q <= best_pkg_d;
      best_die_q <= best_die_d;
    end
  end

  // Page memories: one port each, read data registered.
  always_ff @(posedge clk_i) begin
    if (mem_we && (state_q == ST_CLEAR || !is_read)) begin
      wcnt_mem[addr] <= cnt_wdata;
      if (avg_we) begin
        wavg_mem[addr] <= (state_q == ST_CLEAR) ? '0 : avg_wdata;
      end
    end
    if (mem_we && (state_q == ST_CLEAR || is_read)) begin
      rcnt_mem[addr] <= cnt_wdata;
      if (avg_we) begin
        ravg_mem[addr] <= (state_q == ST_CLEAR) ? '0 : avg_wdata;
      end
    end
    wcnt_rd_q <= wcnt_mem[addr];
    rcnt_rd_q <= rcnt_mem[addr];
    wavg_rd_q <= wavg_mem[addr];
    ravg_rd_q <= ravg_mem[addr];
  end

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      mode_q    <= mode_i;
      page_q    <= lpage_i;
      want_q    <= want_rd_hot_i;
      die_ok_q  <= ({30'd0, package_req_i} < PACKAGES) && ({30'd0, die_i} < DIES_PER_PACKAGE);
      die_idx_q <= DieW'({30'd0, package_req_i} * DIES_PER_PACKAGE + {30'd0, die_i});
    end
  end

  // Control and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WinW'(4096);
      kick_q      <= KickW'(8192);
      wsum_q      <= '0;
      rsum_q      <= '0;
      wseen_q     <= '0;
      rseen_q     <= '0;
      wpos_q      <= '0;
      rpos_q      <= '0;
      fold_q      <= 1'b0;
      wh_q        <= 1'b0;
      rh_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DIES; i++) begin
        dwr_q[i] <= '0;
        drd_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WINDOW) begin
          win_len_q <= cfg_data_i[WinW-1:0];
        end else begin
          kick_q <= cfg_data_i[KickW-1:0];
        end
      end
      if (state_q == ST_EVT_RD) begin
        // Advance seen count and window position; flag a window end.
        if (is_read) begin
          if (rseen_q != TotalMax) rseen_q <= rseen_q + 1'b1;
          rpos_q <= win_end ? '0 : pos_next;
        end else begin
          if (wseen_q != TotalMax) wseen_q <= wseen_q + 1'b1;
          wpos_q <= win_end ? '0 : pos_next;
        end
        fold_q <= win_end;
      end
      if (state_q == ST_DIE_HALF) begin
        if (is_read) rsum_q <= acc_q;
        else         wsum_q <= acc_q;
        for (int i = 0; i < DIES; i++) begin
          if (is_read) drd_q[i] <= drd_q[i] >> 1;
          else         dwr_q[i] <= dwr_q[i] >> 1;
        end
      end
      if (state_q == ST_DIE_INC && die_ok_q) begin
        if (is_read) begin
          if (drd_q[die_idx_q] != TotalMax) drd_q[die_idx_q] <= drd_q[die_idx_q] + 1'b1;
        end else begin
          if (dwr_q[die_idx_q] != TotalMax) dwr_q[die_idx_q] <= dwr_q[die_idx_q] + 1'b1;
        end
      end
      if (state_q == ST_HOT_CMP) begin
        wh_q        <= !warm || ((PAGES == (1 << PageW)) ?
                       ((SumW'(hot_avg_w) << PageW) >= wsum_q) :
                       ((SumW'(hot_avg_w) * SumW'(PAGES)) >= wsum_q));
        rh_q        <= !warm || ((PAGES == (1 << PageW)) ?
                       ((SumW'(hot_avg_r) << PageW) >= rsum_q) :
                       ((SumW'(hot_avg_r) * SumW'(PAGES)) >= rsum_q));
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign wr_hot_o         = wh_q;
  assign rd_hot_o         = rh_q;
  assign target_found_o   = (mode_q == MODE_TARGET) && found_q;
  assign target_package_o = target_found_o ? best_pkg_q : 2'd0;
  assign target_die_o     = target_found_o ? best_die_q : 2'd0;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("request taken while result pending");
  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_DONE)) else $error("result outside done state");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD_WR) |=> (state_q == ST_FOLD_RD || state_q == ST_DIE_HALF))
    else $error("fold walk broken");

endmodule
